[design/dsrm_pkg.sv]
// Package for the dot-star regex matcher: request kinds, field widths, item type.
// No dependencies; imported by the matcher top level (the closure unit uses none of it).
`timescale 1ns / 1ps

package dsrm_pkg;

  localparam int ACTION_W  = 2;
  localparam int INDEX_W   = 4;
  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 5;
  localparam int IN_DATA_W = 24;
  localparam int OUT_DATA_W = 8;

  typedef logic [ACTION_W-1:0] action_t;
  typedef logic [BYTE_W-1:0]   byte_t;
  typedef logic [PLEN_W-1:0]   plen_t;

  localparam action_t ACT_WRITE = 2'd0;
  localparam action_t ACT_TEXT  = 2'd1;
  localparam action_t ACT_END   = 2'd2;
  localparam action_t ACT_NONE  = 2'd3;

  localparam byte_t ANY_BYTE = 8'd46;

  typedef struct packed {
    action_t              action;
    logic [INDEX_W-1:0]   element_index;
    byte_t                pattern_char;
    logic                 repeat_req;
    byte_t                text_char;
  } item_t;

  typedef struct packed {
    logic matched;
    logic any_alive;
    logic is_verdict;
  } result_t;

endpackage

[design/dot_star_regex_matcher_top.sv]
// Dot-star regex matcher top level: pattern table, live-position set, stream ports.
// Depends on dsrm_pkg and dsrm_closure.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser=action, tdata=item fields
//  out_    | out | out_tvalid/tready  | tdata=matched,any_alive; tlast=verdict
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data=pattern_length
//
// One request per cycle while the output is not stalled; an accepted request lands in the
// input register, then goes through the closure/step/closure path into the result register.
// On each accepted text request the live set feeds back to itself through the first closure and the step.
// Reset clears the length, the live set (start position only) and all valids;
// the pattern table holds garbage until written.
// A stalled result holds in the output register while the input register
// still takes one more request; pattern writes never wait on the output.
`timescale 1ns / 1ps

module dot_star_regex_matcher_top #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  dsrm_pkg::action_t                in_tuser,   // [1:0] action
  // [3:0] element_index, [11:4] pattern_char, [12] repeat_req,
  // [20:13] text_char, [23:21] zero
  input  logic [dsrm_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dsrm_pkg::OUT_DATA_W-1:0]  out_tdata,  // [0] matched, [1] any_alive
  output logic                             out_tlast,  // is_verdict
  input  logic                             cfg_wr_en,
  input  dsrm_pkg::plen_t                  cfg_wr_data
);

  import dsrm_pkg::*;

  localparam int NP = MAX_ELEMENTS + 1;
  localparam int LW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam logic [31:0] NMAX = 32'(MAX_ELEMENTS);

  plen_t                plen_r;
  logic [NP-1:0]        live_r, live_nxt;
  byte_t                bytes_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] reps_r;

  logic                 s_vld_r;
  item_t                s_item_r;
  logic                 o_vld_r;
  result_t              o_res_r, o_res_nxt;

  logic                 s_fire, out_free, needs_out;
  logic [31:0]          plen32, len32, idx32;
  logic [LW-1:0]        len;
  logic [NP-1:0]        in_use, link, raw0, closed0, step_raw, closed1, closed_sel;
  logic [MAX_ELEMENTS-1:0] act;

  // request flow
  assign out_free  = !o_vld_r || out_tready;
  assign needs_out = (s_item_r.action == ACT_TEXT) || (s_item_r.action == ACT_END);
  assign s_fire    = s_vld_r && (!needs_out || out_free);
  assign in_tready = !s_vld_r || s_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_tready) begin
      s_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s_item_r.action        <= in_tuser;
      s_item_r.element_index <= in_tdata[3:0];
      s_item_r.pattern_char  <= in_tdata[11:4];
      s_item_r.repeat_req    <= in_tdata[12];
      s_item_r.text_char     <= in_tdata[20:13];
    end
  end

  // pattern length, saturated to the table size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r <= '0;
    end else if (cfg_wr_en) begin
      plen_r <= cfg_wr_data;
    end
  end

  assign plen32 = 32'(plen_r);
  assign len32  = (plen32 > NMAX) ? NMAX : plen32;
  assign len    = len32[LW-1:0];

  // pattern table
  assign idx32 = 32'(s_item_r.element_index);

  always_ff @(posedge clk) begin
    if (s_fire && (s_item_r.action == ACT_WRITE) && (idx32 < NMAX)) begin
      bytes_r[idx32[IW-1:0]] <= s_item_r.pattern_char;
      reps_r[idx32[IW-1:0]]  <= s_item_r.repeat_req;
    end
  end

  // live set update
  always_comb begin
    for (int i = 0; i < NP; i++) begin
      in_use[i] = (32'(i) <= len32);
    end
  end

  assign link = {reps_r, 1'b0};
  assign raw0 = live_r & in_use;

  dsrm_closure #(.N_POS(NP)) u_close_cur (
    .raw    (raw0),
    .link   (link),
    .closed (closed0)
  );

  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      act[i] = closed0[i] & in_use[i+1] &
               ((bytes_r[i] == ANY_BYTE) || (bytes_r[i] == s_item_r.text_char));
    end
    step_raw = '0;
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      step_raw[i]   = step_raw[i]   | (act[i] & reps_r[i]);
      step_raw[i+1] = step_raw[i+1] | (act[i] & ~reps_r[i]);
    end
  end

  dsrm_closure #(.N_POS(NP)) u_close_nxt (
    .raw    (step_raw & in_use),
    .link   (link),
    .closed (closed1)
  );

  always_comb begin
    live_nxt   = live_r;
    closed_sel = closed0 & in_use;
    case (s_item_r.action)
      ACT_TEXT: begin
        live_nxt   = step_raw;
        closed_sel = closed1 & in_use;
      end
      ACT_END: begin
        live_nxt = {{(NP-1){1'b0}}, 1'b1};
      end
      default: begin
        live_nxt = live_r;
      end
    endcase
    o_res_nxt.matched    = closed_sel[len];
    o_res_nxt.any_alive  = |closed_sel;
    o_res_nxt.is_verdict = (s_item_r.action == ACT_END);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= {{(NP-1){1'b0}}, 1'b1};
    end else if (s_fire) begin
      live_r <= live_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (out_free) begin
      o_vld_r <= s_fire && needs_out;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire && needs_out) begin
      o_res_r <= o_res_nxt;
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = {{(OUT_DATA_W-2){1'b0}}, o_res_r.any_alive, o_res_r.matched};
  assign out_tlast  = o_res_r.is_verdict;

endmodule

[design/dsrm_closure.sv]
// Epsilon closure of a live-position set over starred elements.
// Parallel-prefix OR chain, ceil(log2(positions)) levels; uses no package items.
`timescale 1ns / 1ps

module dsrm_closure #(
  parameter int N_POS = 17
) (
  input  logic [N_POS-1:0] raw,
  input  logic [N_POS-1:0] link,   // link[i]: position i reached free from i-1
  output logic [N_POS-1:0] closed
);

  localparam int LV = (N_POS > 1) ? $clog2(N_POS) : 1;

  logic [N_POS-1:0] g [LV+1];
  logic [N_POS-1:0] p [LV+1];

  always_comb begin
    g[0] = raw;
    p[0] = link;
    for (int lv = 0; lv < LV; lv++) begin
      for (int i = 0; i < N_POS; i++) begin
        if (i >= (1 << lv)) begin
          g[lv+1][i] = g[lv][i] | (p[lv][i] & g[lv][i-(1 << lv)]);
          p[lv+1][i] = p[lv][i] & p[lv][i-(1 << lv)];
        end else begin
          g[lv+1][i] = g[lv][i];
          p[lv+1][i] = p[lv][i];
        end
      end
    end
  end

  assign closed = g[LV];

endmodule
